// ===== hdl/ibfd_pkg.sv =====
// Shared types and constants for the bi-phase IR frame decoder.
package ibfd_pkg;

    localparam int INTERVAL_W = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Result field widths
    localparam int BIT_COUNT_W  = 4;
    localparam int FRAME_BITS_W = 14;
    localparam int NIBBLE_W     = 4;

    // Frame positions shown on the result word
    localparam int TOGGLE_POS = 2;
    localparam int NIBBLE_LO  = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX  = 2'd3;

    // Reset values of the timing windows, in microseconds
    localparam logic [CFG_DATA_W-1:0] SHORT_MIN_RST = 16'd700;
    localparam logic [CFG_DATA_W-1:0] SHORT_MAX_RST = 16'd1100;
    localparam logic [CFG_DATA_W-1:0] LONG_MIN_RST  = 16'd1500;
    localparam logic [CFG_DATA_W-1:0] LONG_MAX_RST  = 16'd2000;

    // Input function codes
    localparam logic FUNC_EDGE  = 1'b0;
    localparam logic FUNC_REARM = 1'b1;

    // Depth of the queue between classifier and frame builder
    localparam int QUEUE_DEPTH = 2;

    // Classified word handed from the front to the back
    typedef struct packed {
        logic rearm;
        logic short_hit;
        logic long_hit;
    } class_t;

endpackage

// ===== hdl/ibfd_if.sv =====
// Valid/ready channel interfaces for the decoder's input and result words.
interface ibfd_in_if import ibfd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [INTERVAL_W-1:0] interval_us;

    modport source (output valid, output func, output interval_us, input ready);
    modport sink   (input valid, input func, input interval_us, output ready);
endinterface

interface ibfd_out_if import ibfd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [BIT_COUNT_W-1:0]  bit_count;
    logic [FRAME_BITS_W-1:0] frame_bits;
    logic                    frame_done;
    logic                    toggle_flag;
    logic [NIBBLE_W-1:0]     top_nibble_reversed;

    modport source (output valid, output bit_count, output frame_bits, output frame_done,
                    output toggle_flag, output top_nibble_reversed, input ready);
    modport sink   (input valid, input bit_count, input frame_bits, input frame_done,
                    input toggle_flag, input top_nibble_reversed, output ready);
endinterface

// ===== hdl/ibfd_front.sv =====
// Front end: timing window registers and classification of incoming words.
module ibfd_front import ibfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    ibfd_in_if.sink               in,
    output logic                  push_valid,
    input  logic                  push_ready,
    output class_t                push_word
);

    logic [CFG_DATA_W-1:0] short_min_reg;
    logic [CFG_DATA_W-1:0] short_max_reg;
    logic [CFG_DATA_W-1:0] long_min_reg;
    logic [CFG_DATA_W-1:0] long_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_min_reg <= SHORT_MIN_RST;
            short_max_reg <= SHORT_MAX_RST;
            long_min_reg  <= LONG_MIN_RST;
            long_max_reg  <= LONG_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SHORT_MIN: short_min_reg <= cfg_wdata;
                REG_SHORT_MAX: short_max_reg <= cfg_wdata;
                REG_LONG_MIN:  long_min_reg  <= cfg_wdata;
                REG_LONG_MAX:  long_max_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        push_word.rearm     = (in.func == FUNC_REARM);
        push_word.short_hit = (in.interval_us >= short_min_reg) &&
                              (in.interval_us <= short_max_reg);
        push_word.long_hit  = (in.interval_us >= long_min_reg) &&
                              (in.interval_us <= long_max_reg);
    end

    assign push_valid = in.valid;
    assign in.ready   = push_ready;

endmodule

// ===== hdl/ibfd_queue.sv =====
// Short queue of classified words between front and back.
module ibfd_queue import ibfd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  class_t push_word,
    output logic   pop_valid,
    input  logic   pop_ready,
    output class_t pop_word
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    class_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            // advance pointers, wrapping at the queue depth
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/ibfd_back.sv =====
// Back end: frame builder that applies classified words and holds the result word.
module ibfd_back import ibfd_pkg::*;
#(
    parameter int FRAME_LEN = 14
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pop_valid,
    output logic   pop_ready,
    input  class_t pop_word,
    ibfd_out_if.source out
);

    localparam int CNT_W   = $clog2(FRAME_LEN + 1);
    localparam int IDX_W   = $clog2(FRAME_LEN);
    localparam int STORE_W = (FRAME_LEN > FRAME_BITS_W) ? FRAME_LEN : FRAME_BITS_W;
    localparam int CPAD_W  = (CNT_W > BIT_COUNT_W) ? CNT_W : BIT_COUNT_W;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(FRAME_LEN);

    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 half_reg;
    logic                 half_next;
    logic [FRAME_LEN-1:0] store_reg;
    logic [FRAME_LEN-1:0] store_next;
    logic                 valid_reg;
    logic                 take;
    logic                 last_a;
    logic                 last_b;
    logic [STORE_W-1:0]   store_pad;
    logic [CPAD_W-1:0]    cnt_pad;

    assign pop_ready = !valid_reg || out.ready;
    assign take      = pop_valid && pop_ready;

    always_comb
    begin
        cnt_next   = cnt_reg;
        half_next  = half_reg;
        store_next = store_reg;
        last_a     = 1'b0;
        last_b     = 1'b0;
        if (take)
        begin
            if (pop_word.rearm)
            begin
                // rearm only once the frame is complete; stored bits stay
                if (cnt_reg == FULL)
                begin
                    cnt_next  = '0;
                    half_next = 1'b0;
                end
            end
            else if (cnt_reg == '0)
            begin
                store_next[0] = 1'b1;
                cnt_next      = CNT_W'(1);
            end
            else if (cnt_reg < FULL)
            begin
                if (pop_word.short_hit)
                begin
                    if (half_reg)
                    begin
                        // second half bit repeats the previous bit
                        store_next[cnt_reg[IDX_W-1:0]] = store_reg[IDX_W'(cnt_reg - CNT_W'(1))];
                        cnt_next  = cnt_reg + CNT_W'(1);
                        half_next = 1'b0;
                    end
                    else
                        half_next = 1'b1;
                end
                if (pop_word.long_hit)
                begin
                    if (cnt_next < FULL)
                    begin
                        last_a = store_next[IDX_W'(cnt_next - CNT_W'(1))];
                        if (half_next)
                        begin
                            // odd half pending: previous bit, then its inverse
                            store_next[cnt_next[IDX_W-1:0]] = last_a;
                            cnt_next = cnt_next + CNT_W'(1);
                            last_b   = ~last_a;
                            if (cnt_next < FULL)
                            begin
                                store_next[cnt_next[IDX_W-1:0]] = last_b;
                                cnt_next = cnt_next + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            store_next[cnt_next[IDX_W-1:0]] = ~last_a;
                            cnt_next = cnt_next + CNT_W'(1);
                        end
                    end
                    half_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            half_reg  <= 1'b0;
            store_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            half_reg  <= half_next;
            store_reg <= store_next;
            if (take)
                valid_reg <= 1'b1;
            else if (out.ready)
                valid_reg <= 1'b0;
        end
    end

    // the frame state is the result register: it only moves when a word is taken
    assign store_pad = STORE_W'(store_reg);
    assign cnt_pad   = CPAD_W'(cnt_reg);

    assign out.valid               = valid_reg;
    assign out.bit_count           = cnt_pad[BIT_COUNT_W-1:0];
    assign out.frame_bits          = store_pad[FRAME_BITS_W-1:0];
    assign out.frame_done          = (cnt_reg == FULL);
    assign out.toggle_flag         = store_pad[TOGGLE_POS];
    assign out.top_nibble_reversed = {store_pad[NIBBLE_LO], store_pad[NIBBLE_LO + 1],
                                      store_pad[NIBBLE_LO + 2], store_pad[NIBBLE_LO + 3]};

endmodule

// ===== hdl/ir_biphase_frame_decoder.sv =====
// Bi-phase IR frame decoder: takes one edge or rearm word per cycle and returns one result
// word per input word, showing bit count, frame bits, done, toggle bit and the reversed top
// nibble after that word. A word passes the window compare in the front, waits in a two-entry
// queue and updates the frame state in the back, which registers the result word; one word per
// cycle is sustained while the result side keeps taking. The user writes the window registers
// via cfg_we/cfg_index/cfg_wdata only while the block is idle; the block does not enforce it.
module ir_biphase_frame_decoder import ibfd_pkg::*;
#(
    parameter int FRAME_LEN = 14
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    ibfd_in_if.sink               in,
    ibfd_out_if.source            out
);

    logic   push_valid;
    logic   push_ready;
    class_t push_word;
    logic   pop_valid;
    logic   pop_ready;
    class_t pop_word;

    ibfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in         (in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    ibfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    ibfd_back #(
        .FRAME_LEN (FRAME_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_word  (pop_word),
        .out       (out)
    );

endmodule

// ===== verif/ir_biphase_frame_decoder_test.sv =====
// Self-checking testbench for the bi-phase IR frame decoder: directed and random frames.
`timescale 1ns / 100ps

module ir_biphase_frame_decoder_test;
    import ibfd_pkg::*;

    localparam int FRAME_LEN    = 14;
    localparam int BIT_IDX_W    = $clog2(FRAME_LEN);
    localparam int DRAIN_CYCLES = 6;
    localparam int QUIET_LIMIT  = 5000;
    localparam int STALL_CYCLES = 300;

    typedef struct packed {
        logic [BIT_COUNT_W-1:0]  cnt;
        logic [FRAME_BITS_W-1:0] bits;
        logic                    done;
        logic                    tog;
        logic [NIBBLE_W-1:0]     nib;
    } frame_view_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    ibfd_in_if  word_in ();
    ibfd_out_if word_out ();

    ir_biphase_frame_decoder #(.FRAME_LEN(FRAME_LEN)) u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in        (word_in),
        .out       (word_out)
    );

    // Decoder state as the testbench sees it
    int unsigned           rx_count;
    logic [1:0]            half_pend;
    logic [FRAME_LEN-1:0]  rx_bits;
    logic [CFG_DATA_W-1:0] win_smin;
    logic [CFG_DATA_W-1:0] win_smax;
    logic [CFG_DATA_W-1:0] win_lmin;
    logic [CFG_DATA_W-1:0] win_lmax;

    frame_view_t expected_views[$];

    int unsigned words_sent;
    int unsigned views_checked;
    int unsigned frames_completed;
    int unsigned rearms_taken;
    int unsigned bits_dropped;
    int unsigned settings_used;
    int unsigned mismatches;
    int unsigned stalls_asked = 0;
    int unsigned stalls_served = 0;
    int          src_idle_pct = 38;
    int          sink_idle_pct = 38;
    int          hold_cycles = 0;
    int          quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void push_bit(input logic v);
        if (rx_count >= FRAME_LEN)
        begin
            bits_dropped++;
            return;
        end
        rx_bits[BIT_IDX_W'(rx_count)] = v;
        rx_count++;
    endfunction

    function automatic logic prev_bit();
        if (rx_count == 0)
            return 1'b0;
        return rx_bits[BIT_IDX_W'(rx_count - 1)];
    endfunction

    // Advance the frame state by one word and queue the view it leaves on the output
    function automatic void decode_word(input logic f, input logic [INTERVAL_W-1:0] t);
        frame_view_t v;
        logic        p;
        int unsigned was;
        was = rx_count;
        if (f == FUNC_REARM)
        begin
            if (rx_count == FRAME_LEN)
            begin
                rx_count  = 0;
                half_pend = 2'd0;
                rearms_taken++;
            end
        end
        else if (rx_count == 0)
            push_bit(1'b1);
        else if (rx_count < FRAME_LEN)
        begin
            // short rule first, then long; both may fire when the windows overlap
            if (t >= win_smin && t <= win_smax)
            begin
                half_pend = half_pend + 2'd1;
                if (half_pend == 2'd2)
                begin
                    push_bit(prev_bit());
                    half_pend = 2'd0;
                end
            end
            if (t >= win_lmin && t <= win_lmax)
            begin
                half_pend = half_pend + 2'd2;
                if (half_pend == 2'd2)
                    push_bit(~prev_bit());
                else if (half_pend == 2'd3)
                begin
                    p = prev_bit();
                    push_bit(p);
                    push_bit(~p);
                end
                half_pend = 2'd0;
            end
        end
        if (was < FRAME_LEN && rx_count == FRAME_LEN)
            frames_completed++;
        v.cnt  = rx_count[BIT_COUNT_W-1:0];
        v.bits = rx_bits;
        v.done = (rx_count == FRAME_LEN);
        v.tog  = rx_bits[TOGGLE_POS];
        v.nib  = {rx_bits[NIBBLE_LO], rx_bits[NIBBLE_LO + 1],
                  rx_bits[NIBBLE_LO + 2], rx_bits[NIBBLE_LO + 3]};
        expected_views.push_back(v);
    endfunction

    // Check each result word
    always @(posedge clk)
    begin : check_results
        frame_view_t got;
        frame_view_t want;
        if (rst_n && word_out.valid && word_out.ready)
        begin
            got.cnt  = word_out.bit_count;
            got.bits = word_out.frame_bits;
            got.done = word_out.frame_done;
            got.tog  = word_out.toggle_flag;
            got.nib  = word_out.top_nibble_reversed;
            if (expected_views.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with none expected: count %0d bits %h",
                             $time, got.cnt, got.bits);
            end
            else
            begin
                want = expected_views.pop_front();
                views_checked++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: mismatch exp/act: count %0d/%0d bits %h/%h done %b/%b",
                                 $time, want.cnt, got.cnt, want.bits, got.bits,
                                 want.done, got.done);
                        $display("    toggle %b/%b nibble %h/%h",
                                 want.tog, got.tog, want.nib, got.nib);
                    end
                end
            end
        end
    end

    // Drive the result ready: random idling, or a long hold once a stall is asked for
    always @(posedge clk)
    begin : sink_ready
        if (stalls_served != stalls_asked)
        begin
            stalls_served  <= stalls_asked;
            hold_cycles    <= STALL_CYCLES;
            word_out.ready <= 1'b0;
        end
        else if (hold_cycles != 0)
        begin
            word_out.ready <= 1'b0;
            hold_cycles    <= hold_cycles - 1;
        end
        else
            word_out.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((word_in.valid && word_in.ready) || (word_out.valid && word_out.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one word, hold it until taken, then maybe idle
    task automatic send_word(input logic f, input logic [INTERVAL_W-1:0] t);
        word_in.valid       <= 1'b1;
        word_in.func        <= f;
        word_in.interval_us <= t;
        do
            @(posedge clk);
        while (!word_in.ready);
        decode_word(f, t);
        words_sent++;
        while ($urandom_range(99, 0) < src_idle_pct)
        begin
            word_in.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        word_in.valid <= 1'b0;
        while (expected_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge clk);
        case (idx)
            REG_SHORT_MIN: win_smin = d;
            REG_SHORT_MAX: win_smax = d;
            REG_LONG_MIN:  win_lmin = d;
            REG_LONG_MAX:  win_lmax = d;
            default: ;
        endcase
    endtask

    task automatic set_windows(input logic [CFG_DATA_W-1:0] smin,
                               input logic [CFG_DATA_W-1:0] smax,
                               input logic [CFG_DATA_W-1:0] lmin,
                               input logic [CFG_DATA_W-1:0] lmax);
        wait_drained();
        write_reg(REG_SHORT_MIN, smin);
        write_reg(REG_SHORT_MAX, smax);
        write_reg(REG_LONG_MIN, lmin);
        write_reg(REG_LONG_MAX, lmax);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Interval inside a window, often right on its edges; anything when the window is empty
    function automatic logic [INTERVAL_W-1:0] pick_in(input logic [CFG_DATA_W-1:0] lo,
                                                      input logic [CFG_DATA_W-1:0] hi);
        if (lo > hi)
            return INTERVAL_W'($urandom_range(65535, 0));
        case ($urandom_range(9, 0))
            0: return lo;
            1: return hi;
            default: return INTERVAL_W'($urandom_range(hi, lo));
        endcase
    endfunction

    task automatic send_noise();
        case ($urandom_range(5, 0))
            0: send_word(FUNC_REARM, INTERVAL_W'($urandom_range(65535, 0)));
            1: send_word(FUNC_EDGE, win_smin - 16'd1);
            2: send_word(FUNC_EDGE, win_smax + 16'd1);
            3: send_word(FUNC_EDGE, win_lmin - 16'd1);
            4: send_word(FUNC_EDGE, win_lmax + 16'd1);
            default: send_word(FUNC_EDGE, INTERVAL_W'($urandom_range(65535, 0)));
        endcase
    endtask

    // One frame of half and full bit intervals, a few trailing edges, then a rearm
    task automatic send_frame(input int noise_pct);
        int steps;
        steps = 0;
        send_word(FUNC_EDGE, INTERVAL_W'($urandom_range(65535, 0)));
        while (rx_count < FRAME_LEN && steps < 40)
        begin
            if ($urandom_range(99, 0) < noise_pct)
                send_noise();
            else if ($urandom_range(99, 0) < 55)
                send_word(FUNC_EDGE, pick_in(win_smin, win_smax));
            else
                send_word(FUNC_EDGE, pick_in(win_lmin, win_lmax));
            steps++;
        end
        repeat ($urandom_range(2, 0))
            send_word(FUNC_EDGE, INTERVAL_W'($urandom_range(65535, 0)));
        send_word(FUNC_REARM, INTERVAL_W'($urandom_range(65535, 0)));
    endtask

    task automatic run_frames(input int unsigned count, input int noise_pct);
        int unsigned start;
        start = words_sent;
        while (words_sent - start < count)
            send_frame(noise_pct);
    endtask

    task automatic test_default_windows();
        send_word(FUNC_REARM, 16'hFFFF);          // rearm on an empty frame: ignored
        send_word(FUNC_EDGE, 16'hFFFF);           // first edge, interval ignored
        send_word(FUNC_EDGE, 16'h0000);
        send_word(FUNC_EDGE, SHORT_MIN_RST);
        send_word(FUNC_EDGE, SHORT_MAX_RST);      // second half bit: copy
        send_word(FUNC_EDGE, LONG_MIN_RST);
        send_word(FUNC_EDGE, LONG_MAX_RST);
        send_word(FUNC_EDGE, SHORT_MIN_RST - 16'd1);
        send_word(FUNC_EDGE, LONG_MAX_RST + 16'd1);
        send_word(FUNC_EDGE, 16'd1300);           // between the windows
        send_word(FUNC_EDGE, SHORT_MAX_RST - 16'd1);
        send_word(FUNC_EDGE, LONG_MIN_RST + 16'd1);  // long after a half: two bits
        send_word(FUNC_REARM, 16'h0000);          // rearm mid-frame: ignored
        while (rx_count < FRAME_LEN - 1)
            send_word(FUNC_EDGE, 16'd1800);
        send_word(FUNC_EDGE, 16'd800);
        send_word(FUNC_EDGE, 16'd1600);           // one slot left: second bit dropped
        send_word(FUNC_EDGE, 16'd900);            // frame full: no change
        send_word(FUNC_REARM, 16'hFFFF);
        send_word(FUNC_EDGE, 16'd1);
        send_word(FUNC_EDGE, 16'd1000);
        send_word(FUNC_EDGE, 16'd1000);
    endtask

    task automatic test_window_extremes();
        set_windows(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);  // both windows cover everything
        run_frames(60, 5);
        set_windows(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);  // no short window
        run_frames(50, 5);
        set_windows(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        run_frames(50, 5);
        set_windows(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);  // nothing past the first bit
        run_frames(20, 20);
        set_windows(16'd600, 16'd1300, 16'd1200, 16'd2100);   // partial overlap
        run_frames(60, 10);
    endtask

    task automatic test_random_frames();
        logic [CFG_DATA_W-1:0] smin;
        logic [CFG_DATA_W-1:0] smax;
        logic [CFG_DATA_W-1:0] lmin;
        logic [CFG_DATA_W-1:0] lmax;
        set_windows(SHORT_MIN_RST, SHORT_MAX_RST, LONG_MIN_RST, LONG_MAX_RST);
        run_frames(400, 8);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_frames(200, 8);
        src_idle_pct  = 38;
        sink_idle_pct = 38;
        run_frames(150, 50);
        repeat (2)
        begin
            smin = CFG_DATA_W'($urandom_range(1000, 200));
            smax = smin + CFG_DATA_W'($urandom_range(600, 0));
            lmin = smax + CFG_DATA_W'($urandom_range(800, 0));
            lmax = lmin + CFG_DATA_W'($urandom_range(1500, 0));
            set_windows(smin, smax, lmin, lmax);
            run_frames(120, 10);
        end
    endtask

    task automatic test_output_backpressure();
        src_idle_pct = 0;
        stalls_asked++;
        run_frames(40, 0);
        src_idle_pct = 38;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_SHORT_MIN;
        cfg_wdata           = '0;
        word_in.valid       = 1'b0;
        word_in.func        = FUNC_EDGE;
        word_in.interval_us = '0;
        rx_count            = 0;
        half_pend           = 2'd0;
        rx_bits             = '0;
        win_smin            = SHORT_MIN_RST;
        win_smax            = SHORT_MAX_RST;
        win_lmin            = LONG_MIN_RST;
        win_lmax            = LONG_MAX_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_windows();
        test_window_extremes();
        test_random_frames();
        test_output_backpressure();

        wait_drained();
        if (expected_views.size() != 0)
            $display("%0d result words never arrived", expected_views.size());
        $display("Sent %0d words, checked %0d results: %0d frames done, %0d rearms, %0d bits dropped",
                 words_sent, views_checked, frames_completed, rearms_taken, bits_dropped);
        $display("Ran %0d window settings, with random gaps, a gap-free stretch and a result stall",
                 settings_used);
        if (mismatches == 0 && expected_views.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ibfd_pkg.sv
hdl/ibfd_if.sv
hdl/ibfd_front.sv
hdl/ibfd_queue.sv
hdl/ibfd_back.sv
hdl/ir_biphase_frame_decoder.sv
verif/ir_biphase_frame_decoder_test.sv
